FILE: hdl/irat_pkg.sv
`default_nettype none

package irat_pkg;

  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int USED_W = 11;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_MERGED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
  } entry_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

FILE: hdl/irat_mem.sv
`default_nettype none

module irat_mem
  import irat_pkg::*;
#(
  parameter int DEPTH = TABLE_ENTRIES_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire mem_ctl_t      mem_ctl,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/irat_ctrl.sv
`default_nettype none

module irat_ctrl
  import irat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int IW = $clog2(TABLE_ENTRIES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_opcode,
  input  wire logic [31:0]   in_range_start,
  input  wire logic [31:0]   in_range_end,
  input  wire logic [31:0]   in_query_address,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_allowed,
  output logic [1:0]         out_status,
  output logic [USED_W-1:0]  out_entries_used,
  output mem_ctl_t           mem_ctl,
  output logic [IW-1:0]      rd_addr,
  input  wire entry_t        rd_data,
  output logic [IW-1:0]      wr_addr,
  output entry_t             wr_data
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int LW = CW + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_PLACE = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [31:0]          s_r, s_nxt;
  logic [31:0]          e_r, e_nxt;
  logic [31:0]          a_r, a_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [IW-1:0]        mid_r, mid_nxt;
  logic signed [LW-1:0] low_r, low_nxt;
  logic signed [LW-1:0] high_r, high_nxt;
  logic [1:0]           status_r, status_nxt;
  logic                 allowed_r, allowed_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_allowed_r, out_allowed_nxt;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [USED_W-1:0]    out_used_r, out_used_nxt;

  logic                 full;
  logic [CW-1:0]        cnt_dec;
  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        idx_dec;
  logic [CW-1:0]        idx_dec2;
  logic                 found;
  logic [CW-1:0]        pos_sel;
  logic                 hit;
  logic signed [LW-1:0] mid_ext;
  logic signed [LW-1:0] lo_new;
  logic signed [LW-1:0] hi_new;
  logic signed [LW-1:0] sum;

  assign full     = (cnt_r == CW'(TABLE_ENTRIES));
  assign cnt_dec  = cnt_r - CW'(1);
  assign idx_inc  = idx_r + CW'(1);
  assign idx_dec  = idx_r - CW'(1);
  assign idx_dec2 = idx_r - CW'(2);
  assign found    = (s_r < rd_data.first);
  assign pos_sel  = found ? idx_r : cnt_r;

  assign hit     = (rd_data.first <= a_r) && (rd_data.last >= a_r);
  assign mid_ext = $signed({{(LW - IW){1'b0}}, mid_r});
  assign lo_new  = (rd_data.first > a_r) ? low_r : (mid_ext + LW'(1));
  assign hi_new  = (rd_data.first > a_r) ? (mid_ext - LW'(1)) : high_r;
  assign sum     = lo_new + hi_new;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    a_nxt       = a_r;
    idx_nxt     = idx_r;
    pos_nxt     = pos_r;
    mid_nxt     = mid_r;
    low_nxt     = low_r;
    high_nxt    = high_r;
    status_nxt  = status_r;
    allowed_nxt = allowed_r;
    mem_ctl     = '0;
    rd_addr     = '0;
    wr_addr     = '0;
    wr_data     = '{first: s_r, last: e_r};

    out_valid_nxt   = out_valid_r;
    out_allowed_nxt = out_allowed_r;
    out_status_nxt  = out_status_r;
    out_used_nxt    = out_used_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          s_nxt       = in_range_start;
          e_nxt       = in_range_end;
          a_nxt       = in_query_address;
          status_nxt  = ST_DONE;
          allowed_nxt = 1'b0;
          if (in_opcode == OP_INSERT) begin
            if (cnt_r == '0) begin
              pos_nxt   = '0;
              state_nxt = S_PLACE;
            end else begin
              idx_nxt       = '0;
              mem_ctl.rd_en = 1'b1;
              rd_addr       = '0;
              state_nxt     = S_SCAN;
            end
          end else begin
            if (cnt_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              low_nxt       = '0;
              high_nxt      = $signed(LW'(cnt_r)) - LW'(1);
              mid_nxt       = IW'(cnt_dec >> 1);
              mem_ctl.rd_en = 1'b1;
              rd_addr       = IW'(cnt_dec >> 1);
              state_nxt     = S_LOOK;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_data.first == s_r) begin
          status_nxt = ST_MERGED;
          if (e_r > rd_data.last) begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = idx_r[IW-1:0];
          end
          state_nxt = S_DONE;
        end else if (found || (idx_inc == cnt_r)) begin
          pos_nxt = pos_sel;
          if (full) begin
            status_nxt = ST_FULL;
            state_nxt  = S_DONE;
          end else if (pos_sel == cnt_r) begin
            state_nxt = S_PLACE;
          end else begin
            // open the slot: copy entries up from the top down
            mem_ctl.rd_en = 1'b1;
            rd_addr       = cnt_dec[IW-1:0];
            idx_nxt       = cnt_r;
            state_nxt     = S_SHIFT;
          end
        end else begin
          idx_nxt       = idx_inc;
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_inc[IW-1:0];
        end
      end
      S_SHIFT: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx_r[IW-1:0];
        wr_data       = rd_data;
        if (idx_dec == pos_r) begin
          state_nxt = S_PLACE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = idx_dec2[IW-1:0];
          idx_nxt       = idx_dec;
        end
      end
      S_PLACE: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = pos_r[IW-1:0];
        cnt_nxt       = cnt_r + CW'(1);
        status_nxt    = ST_DONE;
        state_nxt     = S_DONE;
      end
      S_LOOK: begin
        if (hit) begin
          allowed_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else if (lo_new <= hi_new) begin
          low_nxt       = lo_new;
          high_nxt      = hi_new;
          mid_nxt       = sum[IW:1];
          mem_ctl.rd_en = 1'b1;
          rd_addr       = sum[IW:1];
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_allowed_nxt = allowed_r;
          out_status_nxt  = status_r;
          out_used_nxt    = USED_W'(cnt_r);
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r           <= s_nxt;
    e_r           <= e_nxt;
    a_r           <= a_nxt;
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    mid_r         <= mid_nxt;
    low_r         <= low_nxt;
    high_r        <= high_nxt;
    status_r      <= status_nxt;
    allowed_r     <= allowed_nxt;
    out_allowed_r <= out_allowed_nxt;
    out_status_r  <= out_status_nxt;
    out_used_r    <= out_used_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_allowed      = out_allowed_r;
  assign out_status       = out_status_r;
  assign out_entries_used = out_used_r;

`ifndef SYNTHESIS
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.rd_en && mem_ctl.wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == $past(cnt_r) + CW'(1)))
    else $error("entry count moved by other than one");

  a_lookup_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOOK) |-> !mem_ctl.wr_en)
    else $error("table written during lookup");

  a_place_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PLACE) |-> !full)
    else $error("insert placed into a full table");
`endif

endmodule

`default_nettype wire

FILE: hdl/ip_range_allow_table_top.sv
// Channel  Ports                                          Direction
// in       in_valid/in_ready, in_opcode, in_range_start,  request in
//          in_range_end, in_query_address
// out      out_valid/out_ready, out_allowed, out_status,  result out
//          out_entries_used
//
// One item at a time; the table is held in one memory with registered reads.
// Lookup: a binary search over the sorted entries, one table read per probe.
// Insert: a linear scan up to the sorted slot, then a shift of the later entries
// up and a write of the new one; the linear scan and the shift set the insert time.
// Reset clears the entry count, state and out_valid; no clearing pass. A stalled
// output holds its result while the next request is already taken.
`default_nettype none

module ip_range_allow_table_top
  import irat_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_opcode,
  input  wire logic [31:0]       in_range_start,
  input  wire logic [31:0]       in_range_end,
  input  wire logic [31:0]       in_query_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_allowed,
  output logic [1:0]             out_status,
  output logic [USED_W-1:0]      out_entries_used
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  mem_ctl_t      mem_ctl;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  entry_t        rd_data;
  entry_t        wr_data;

  irat_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_opcode(in_opcode),
    .in_range_start(in_range_start),
    .in_range_end(in_range_end),
    .in_query_address(in_query_address),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_allowed(out_allowed),
    .out_status(out_status),
    .out_entries_used(out_entries_used),
    .mem_ctl(mem_ctl),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  irat_mem #(
    .DEPTH(TABLE_ENTRIES),
    .AW(IW)
  ) u_mem (
    .clk(clk),
    .mem_ctl(mem_ctl),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

`default_nettype wire
